// ===== rtl/vlfs_pkg.sv =====
package vlfs_pkg;

    localparam int LINE_W        = 9;
    localparam int SKIP_W        = 8;
    localparam int MODE_W        = 8;
    localparam int PAD_W         = 5;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;

    localparam int FRAME_LINES_DEF            = 262;
    localparam int TOP_BORDER_LINE_DEF        = 13;
    localparam int ACTIVE_FIRST_LINE_DEF      = 38;
    localparam int ACTIVE_END_LINE_DEF        = 230;
    localparam int BOTTOM_BORDER_END_LINE_DEF = 256;
    localparam int VBLANK_LINE_DEF            = 0;

    localparam int PAL_PAD_OFFSET    = 23;
    localparam int FIELD_RISE_OFFSET = 31;
    localparam logic [PAD_W-1:0] PAL_PAD_LINES = PAD_W'(25);
    localparam logic [MODE_W-1:0] MODE_NIBBLE_MASK = 8'hf0;

    localparam logic [3:0] MODE_NARROW_A = 4'd8;
    localparam logic [3:0] MODE_NARROW_B = 4'd9;
    localparam logic [3:0] MODE_NARROW_C = 4'd11;
    localparam logic [3:0] MODE_NARROW_D = 4'd13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_SKIP = 1'b0,
        CFG_PAL_TIMING = 1'b1
    } t_cfg_index;

    typedef enum logic {
        ACT_LINE_TICK  = 1'b0,
        ACT_MODE_WRITE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        DRAW_NONE   = 2'd0,
        DRAW_BORDER = 2'd1,
        DRAW_ACTIVE = 2'd2
    } t_draw_kind;

    typedef struct packed {
        logic              action;
        logic [MODE_W-1:0] mode_value;
    } t_in_beat;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [1:0]        draw_kind;
        logic              frame_sync;
        logic              video_vsync;
        logic              field_fall_next;
        logic              field_rise_next;
        logic [PAD_W-1:0]  pad_lines;
        logic              mode_locked;
        logic              wide_fetch;
        logic              mode_taken;
    } t_out_beat;

    typedef struct packed {
        logic [LINE_W-1:0] line_count;
        logic [SKIP_W-1:0] skip_countdown;
        logic              change_lock;
        logic [MODE_W-1:0] stored_mode;
        logic              wide_mode;
    } t_state;

    typedef struct packed {
        logic [SKIP_W-1:0] frame_skip;
        logic              pal_timing;
    } t_cfg;

    function automatic logic decode_wide(input logic [MODE_W-1:0] mode);
        logic [3:0] hi;
        hi = 4'((mode & MODE_NIBBLE_MASK) >> 4);
        return !(hi == MODE_NARROW_A || hi == MODE_NARROW_B ||
                 hi == MODE_NARROW_C || hi == MODE_NARROW_D);
    endfunction

endpackage

// ===== rtl/vlfs_line_core.sv =====
module vlfs_line_core #(
    parameter int FRAME_LINES            = vlfs_pkg::FRAME_LINES_DEF,
    parameter int TOP_BORDER_LINE        = vlfs_pkg::TOP_BORDER_LINE_DEF,
    parameter int ACTIVE_FIRST_LINE      = vlfs_pkg::ACTIVE_FIRST_LINE_DEF,
    parameter int ACTIVE_END_LINE        = vlfs_pkg::ACTIVE_END_LINE_DEF,
    parameter int BOTTOM_BORDER_END_LINE = vlfs_pkg::BOTTOM_BORDER_END_LINE_DEF,
    parameter int VBLANK_LINE            = vlfs_pkg::VBLANK_LINE_DEF
) (
    input  vlfs_pkg::t_state    i_state,
    input  vlfs_pkg::t_cfg      i_cfg,
    input  vlfs_pkg::t_in_beat  i_beat,
    output vlfs_pkg::t_state    o_state,
    output vlfs_pkg::t_out_beat o_beat
);

    localparam int LW = vlfs_pkg::LINE_W;

    localparam int VBLANK_AT     = VBLANK_LINE % FRAME_LINES;
    localparam int ACT_START_AT  = ACTIVE_FIRST_LINE % FRAME_LINES;
    localparam int ACT_END_AT    = ACTIVE_END_LINE % FRAME_LINES;
    localparam int FALL_AT       = (ACTIVE_END_LINE + FRAME_LINES - 1) % FRAME_LINES;
    localparam int PAL_PAD_AT    = (ACTIVE_END_LINE + vlfs_pkg::PAL_PAD_OFFSET) % FRAME_LINES;
    localparam int RISE_AT       = (ACTIVE_END_LINE + vlfs_pkg::FIELD_RISE_OFFSET) % FRAME_LINES;

    logic [LW-1:0] line;
    logic [LW:0]   line_inc;
    logic [LW-1:0] next_line;
    logic [vlfs_pkg::SKIP_W-1:0] next_skip;

    always_comb begin
        o_state = i_state;
        o_beat  = '0;
        line      = i_state.line_count;
        line_inc  = {1'b0, line} + (LW+1)'(1);
        next_line = (line_inc == (LW+1)'(FRAME_LINES)) ? '0 : line_inc[LW-1:0];
        next_skip = i_state.skip_countdown;

        if (i_beat.action == vlfs_pkg::ACT_MODE_WRITE) begin
            o_state.stored_mode = i_beat.mode_value;
            if (!i_state.change_lock) begin
                o_state.wide_mode = vlfs_pkg::decode_wide(i_beat.mode_value);
                o_beat.mode_taken = 1'b1;
            end
        end else begin
            if (i_state.skip_countdown == '0 &&
                {1'b0, line} >= (LW+1)'(TOP_BORDER_LINE + 1)) begin
                priority if ({1'b0, line} < (LW+1)'(ACTIVE_FIRST_LINE)) begin
                    o_beat.draw_kind = vlfs_pkg::DRAW_BORDER;
                end else if ({1'b0, line} < (LW+1)'(ACTIVE_END_LINE)) begin
                    o_beat.draw_kind = vlfs_pkg::DRAW_ACTIVE;
                end else if ({1'b0, line} + (LW+1)'(2) <
                             (LW+1)'(BOTTOM_BORDER_END_LINE)) begin
                    o_beat.draw_kind = vlfs_pkg::DRAW_BORDER;
                end else begin
                    o_beat.draw_kind = vlfs_pkg::DRAW_NONE;
                end
            end
            o_state.line_count = next_line;

            if (next_line == LW'(VBLANK_AT)) begin
                o_beat.frame_sync = 1'b1;
                next_skip = (i_state.skip_countdown == '0) ? i_cfg.frame_skip
                                                           : i_state.skip_countdown - 1'b1;
                o_beat.video_vsync = (next_skip == '0);
            end
            o_state.skip_countdown = next_skip;

            if (next_line == LW'(ACT_START_AT)) begin
                o_state.change_lock = 1'b0;
                o_state.wide_mode   = vlfs_pkg::decode_wide(i_state.stored_mode);
                o_beat.mode_taken   = 1'b1;
            end
            if (next_line == LW'(FALL_AT)) begin
                o_beat.field_fall_next = 1'b1;
            end
            if (next_line == LW'(ACT_END_AT)) begin
                o_state.change_lock = 1'b1;
            end
            if (i_cfg.pal_timing && next_line == LW'(PAL_PAD_AT)) begin
                o_beat.pad_lines = vlfs_pkg::PAL_PAD_LINES;
            end
            if (next_line == LW'(RISE_AT)) begin
                o_beat.field_rise_next = 1'b1;
                if (i_cfg.pal_timing) begin
                    o_beat.pad_lines = vlfs_pkg::PAL_PAD_LINES;
                end
            end
        end

        o_beat.line_number = o_state.line_count;
        o_beat.mode_locked = o_state.change_lock;
        o_beat.wide_fetch  = o_state.wide_mode;
    end

endmodule

// ===== rtl/video_line_frame_sequencer.sv =====
// Line and field sequencer of a video display generator.
// Input channel (i_in_valid / o_in_stall / i_in_beat): one beat per event,
// either a line tick sent at the fall of horizontal sync or a mode byte write.
// Output channel (o_out_valid / i_out_stall / o_out_beat): exactly one result
// beat per input beat, in order: line counter, the kind of line just finished,
// frame/field sync flags, PAL padding, mode lock and fetch width.
// o_out_valid rises in the cycle after acceptance; throughput is one beat per
// cycle unless stalled, set by the one result register behind line/mode logic.
// Configuration (frame_skip at index 0, pal_timing at index 1) is written
// through i_cfg_we / i_cfg_index / i_cfg_data while no beat is in flight.
// Reset (synchronous, i_rst_n low) clears the line counter, skip countdown,
// lock, stored mode and configuration, sets wide fetch, and empties the
// result register. While the receiver stalls a waiting result, the result
// holds and o_in_stall is raised; an unstalled receiver never blocks input.
module video_line_frame_sequencer #(
    parameter int FRAME_LINES            = vlfs_pkg::FRAME_LINES_DEF,
    parameter int TOP_BORDER_LINE        = vlfs_pkg::TOP_BORDER_LINE_DEF,
    parameter int ACTIVE_FIRST_LINE      = vlfs_pkg::ACTIVE_FIRST_LINE_DEF,
    parameter int ACTIVE_END_LINE        = vlfs_pkg::ACTIVE_END_LINE_DEF,
    parameter int BOTTOM_BORDER_END_LINE = vlfs_pkg::BOTTOM_BORDER_END_LINE_DEF,
    parameter int VBLANK_LINE            = vlfs_pkg::VBLANK_LINE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vlfs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [vlfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  vlfs_pkg::t_in_beat                  i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output vlfs_pkg::t_out_beat                 o_out_beat
);

    vlfs_pkg::t_state    r_state;
    vlfs_pkg::t_state    n_state;
    vlfs_pkg::t_cfg      r_cfg;
    logic                r_out_valid;
    vlfs_pkg::t_out_beat r_out_beat;
    vlfs_pkg::t_out_beat n_out_beat;
    logic                accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    vlfs_line_core #(
        .FRAME_LINES            (FRAME_LINES),
        .TOP_BORDER_LINE        (TOP_BORDER_LINE),
        .ACTIVE_FIRST_LINE      (ACTIVE_FIRST_LINE),
        .ACTIVE_END_LINE        (ACTIVE_END_LINE),
        .BOTTOM_BORDER_END_LINE (BOTTOM_BORDER_END_LINE),
        .VBLANK_LINE            (VBLANK_LINE)
    ) u_core (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_beat  (i_in_beat),
        .o_state (n_state),
        .o_beat  (n_out_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vlfs_pkg::CFG_FRAME_SKIP: r_cfg.frame_skip <= i_cfg_data[vlfs_pkg::SKIP_W-1:0];
                vlfs_pkg::CFG_PAL_TIMING: r_cfg.pal_timing <= i_cfg_data[0];
                default:                  r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.line_count     <= '0;
            r_state.skip_countdown <= '0;
            r_state.change_lock    <= 1'b0;
            r_state.stored_mode    <= '0;
            r_state.wide_mode      <= vlfs_pkg::decode_wide('0);
            r_out_valid            <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_beat <= n_out_beat;
        end
    end

endmodule

// ===== rtl/vlfs_checker.sv =====
module vlfs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input vlfs_pkg::t_out_beat o_out_beat
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed or vanished");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_pad_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.pad_lines == vlfs_pkg::PAL_PAD_LINES ||
                        o_out_beat.pad_lines == '0)
        else $error("padding count out of range");

    a_vsync_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.video_vsync |-> o_out_beat.frame_sync)
        else $error("vsync without frame sync");

endmodule

bind video_line_frame_sequencer vlfs_checker u_vlfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

// ===== tb/sv/video_line_frame_sequencer_tb.sv =====
module video_line_frame_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_BEATS = 310;
    localparam int REPORT_LIMIT  = 10;

    localparam int SKIPS [SEGMENTS] = '{0, 2, 1, 0, 3, 255};
    localparam int PALS  [SEGMENTS] = '{1, 0, 1, 0, 1, 1};
    localparam logic [vlfs_pkg::MODE_W-1:0] MODES [10] = '{8'h00, 8'hff, 8'h80, 8'h90, 8'hb0,
                                                           8'hd0, 8'ha0, 8'hc0, 8'h7f, 8'h8f};

    class line_seq_tracker;
        int                          line_now   = 0;
        int                          skip_left  = 0;
        bit                          lock_now   = 1'b0;
        logic [vlfs_pkg::MODE_W-1:0] mode_byte  = '0;
        bit                          wide_now   = 1'b1;
        int                          frame_skip = 0;
        bit                          pal_on     = 1'b0;
        vlfs_pkg::t_out_beat         expected_lines[$];
        int                          faults     = 0;

        function int wrapped(input int v);
            return v % vlfs_pkg::FRAME_LINES_DEF;
        endfunction

        function bit fetch_is_wide(input logic [vlfs_pkg::MODE_W-1:0] m);
            case (m[7:4])
                vlfs_pkg::MODE_NARROW_A, vlfs_pkg::MODE_NARROW_B,
                vlfs_pkg::MODE_NARROW_C, vlfs_pkg::MODE_NARROW_D: return 1'b0;
                default: return 1'b1;
            endcase
        endfunction

        function string show(input vlfs_pkg::t_out_beat b);
            return $sformatf({"line %0d kind %0d fsync %0d vsync %0d fall %0d rise %0d ",
                              "pad %0d lock %0d wide %0d taken %0d"},
                             b.line_number, b.draw_kind, b.frame_sync, b.video_vsync,
                             b.field_fall_next, b.field_rise_next, b.pad_lines,
                             b.mode_locked, b.wide_fetch, b.mode_taken);
        endfunction

        function void note_fault(input string msg);
            faults++;
            if (faults <= REPORT_LIMIT) begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        function void note_beat(input vlfs_pkg::t_in_beat b);
            vlfs_pkg::t_out_beat want;
            int                  prev;
            want = '0;
            if (b.action == vlfs_pkg::ACT_MODE_WRITE) begin
                mode_byte = b.mode_value;
                if (!lock_now) begin
                    wide_now = fetch_is_wide(b.mode_value);
                    want.mode_taken = 1'b1;
                end
            end else begin
                prev = line_now;
                if (skip_left == 0 && prev >= vlfs_pkg::TOP_BORDER_LINE_DEF + 1) begin
                    if (prev < vlfs_pkg::ACTIVE_FIRST_LINE_DEF) begin
                        want.draw_kind = vlfs_pkg::DRAW_BORDER;
                    end else if (prev < vlfs_pkg::ACTIVE_END_LINE_DEF) begin
                        want.draw_kind = vlfs_pkg::DRAW_ACTIVE;
                    end else if (prev + 2 < vlfs_pkg::BOTTOM_BORDER_END_LINE_DEF) begin
                        want.draw_kind = vlfs_pkg::DRAW_BORDER;
                    end
                end
                line_now = wrapped(prev + 1);
                if (line_now == wrapped(vlfs_pkg::VBLANK_LINE_DEF)) begin
                    want.frame_sync = 1'b1;
                    if (skip_left == 0) begin
                        skip_left = frame_skip;
                    end else begin
                        skip_left--;
                    end
                    if (skip_left == 0) begin
                        want.video_vsync = 1'b1;
                    end
                end
                if (line_now == wrapped(vlfs_pkg::ACTIVE_FIRST_LINE_DEF)) begin
                    lock_now = 1'b0;
                    wide_now = fetch_is_wide(mode_byte);
                    want.mode_taken = 1'b1;
                end
                if (line_now == wrapped(vlfs_pkg::ACTIVE_END_LINE_DEF +
                                        vlfs_pkg::FRAME_LINES_DEF - 1)) begin
                    want.field_fall_next = 1'b1;
                end
                if (line_now == wrapped(vlfs_pkg::ACTIVE_END_LINE_DEF)) begin
                    lock_now = 1'b1;
                end
                if (pal_on && line_now == wrapped(vlfs_pkg::ACTIVE_END_LINE_DEF +
                                                  vlfs_pkg::PAL_PAD_OFFSET)) begin
                    want.pad_lines = vlfs_pkg::PAL_PAD_LINES;
                end
                if (line_now == wrapped(vlfs_pkg::ACTIVE_END_LINE_DEF +
                                        vlfs_pkg::FIELD_RISE_OFFSET)) begin
                    want.field_rise_next = 1'b1;
                    if (pal_on) begin
                        want.pad_lines = vlfs_pkg::PAL_PAD_LINES;
                    end
                end
            end
            want.line_number = vlfs_pkg::LINE_W'(line_now);
            want.mode_locked = lock_now;
            want.wide_fetch  = wide_now;
            expected_lines.push_back(want);
        endfunction

        function void compare_result(input vlfs_pkg::t_out_beat got);
            vlfs_pkg::t_out_beat want;
            if (expected_lines.size() == 0) begin
                note_fault({"unexpected result: ", show(got)});
                return;
            end
            want = expected_lines.pop_front();
            if (got.line_number !== want.line_number ||
                got.draw_kind !== want.draw_kind ||
                got.frame_sync !== want.frame_sync ||
                got.video_vsync !== want.video_vsync ||
                got.field_fall_next !== want.field_fall_next ||
                got.field_rise_next !== want.field_rise_next ||
                got.pad_lines !== want.pad_lines ||
                got.mode_locked !== want.mode_locked ||
                got.wide_fetch !== want.wide_fetch ||
                got.mode_taken !== want.mode_taken) begin
                note_fault({"mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
            end
        endfunction

        function int outstanding();
            return expected_lines.size();
        endfunction
    endclass

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [vlfs_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [vlfs_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_stall;
    vlfs_pkg::t_in_beat               i_in_beat   = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    vlfs_pkg::t_out_beat              o_out_beat;

    line_seq_tracker tracker = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    video_line_frame_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tracker.note_beat(i_in_beat);
            end
            if (o_out_valid && !i_out_stall) begin
                tracker.compare_result(o_out_beat);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_beat(input vlfs_pkg::t_action act,
                             input logic [vlfs_pkg::MODE_W-1:0] mode);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_in_beat.action     <= act;
        i_in_beat.mode_value <= mode;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_lines();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input vlfs_pkg::t_cfg_index idx,
                             input logic [vlfs_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == vlfs_pkg::CFG_FRAME_SKIP) begin
            tracker.frame_skip = int'(data);
        end else begin
            tracker.pal_on = data[0];
        end
        @(posedge i_clk);
    endtask

    initial begin
        vlfs_pkg::t_action act;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (MODES[k]) begin
            push_beat(vlfs_pkg::ACT_MODE_WRITE, MODES[k]);
        end
        for (int k = 0; k < 14; k++) begin
            push_beat(vlfs_pkg::ACT_LINE_TICK, (k % 2) ? 8'hff : 8'h00);
        end
        push_beat(vlfs_pkg::ACT_MODE_WRITE, 8'h55);
        drain_lines();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_reg(vlfs_pkg::CFG_FRAME_SKIP, vlfs_pkg::CFG_DATA_W'(SKIPS[seg]));
            write_reg(vlfs_pkg::CFG_PAL_TIMING, vlfs_pkg::CFG_DATA_W'(PALS[seg]));
            case (seg / 2)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < SEGMENT_BEATS; n++) begin
                act = ($urandom_range(99) < 15) ? vlfs_pkg::ACT_MODE_WRITE
                                                : vlfs_pkg::ACT_LINE_TICK;
                push_beat(act, vlfs_pkg::MODE_W'($urandom_range(255)));
            end
            drain_lines();
        end

        if (tracker.faults == 0 && tracker.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
